[rtl/w8b10b_pkg.sv]
// Shared types, code tables and widths for the word 8b/10b encoder.
package w8b10b_pkg;

  localparam int unsigned LANES       = 4;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CODE_W      = 40;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned QUEUE_DEPTH = 2;

  // 3b/4b groups with special handling
  localparam logic [2:0] Y_D0 = 3'd0;
  localparam logic [2:0] Y_D3 = 3'd3;
  localparam logic [2:0] Y_D4 = 3'd4;
  localparam logic [2:0] Y_D7 = 3'd7;

  // 3b/4b forms of D.x.7 (negative disparity form)
  localparam logic [3:0] FOUR_PRI7 = 4'hE;
  localparam logic [3:0] FOUR_ALT7 = 4'h7;

  // Disparity-independent facts about one byte
  typedef struct packed {
    logic [5:0] six;     // abcdei, negative disparity form
    logic       unbal;   // 6b block is not neutral
    logic       flip6;   // complement the 6b block under positive disparity
    logic [3:0] four;    // fghj, negative disparity form (primary for D.x.7)
    logic [2:0] y;       // HGF
  } lane_class_t;

  typedef lane_class_t [LANES-1:0] word_class_t;

  // 5b/6b code, abcdei for negative running disparity
  function automatic logic [5:0] six_neg_f(input logic [4:0] x);
    logic [5:0] r;
    unique case (x)
      5'd0:  r = 6'h27;  5'd1:  r = 6'h1D;  5'd2:  r = 6'h2D;  5'd3:  r = 6'h31;
      5'd4:  r = 6'h35;  5'd5:  r = 6'h29;  5'd6:  r = 6'h19;  5'd7:  r = 6'h38;
      5'd8:  r = 6'h39;  5'd9:  r = 6'h25;  5'd10: r = 6'h15;  5'd11: r = 6'h34;
      5'd12: r = 6'h0D;  5'd13: r = 6'h2C;  5'd14: r = 6'h1C;  5'd15: r = 6'h17;
      5'd16: r = 6'h1B;  5'd17: r = 6'h23;  5'd18: r = 6'h13;  5'd19: r = 6'h32;
      5'd20: r = 6'h0B;  5'd21: r = 6'h2A;  5'd22: r = 6'h1A;  5'd23: r = 6'h3A;
      5'd24: r = 6'h33;  5'd25: r = 6'h26;  5'd26: r = 6'h16;  5'd27: r = 6'h36;
      5'd28: r = 6'h0E;  5'd29: r = 6'h2E;  5'd30: r = 6'h1E;  default: r = 6'h2B;
    endcase
    return r;
  endfunction

  // 3b/4b code, fghj for negative running disparity
  function automatic logic [3:0] four_neg_f(input logic [2:0] y);
    logic [3:0] r;
    unique case (y)
      3'd0: r = 4'hB;
      3'd1: r = 4'h9;
      3'd2: r = 4'h5;
      3'd3: r = 4'hC;
      3'd4: r = 4'hD;
      3'd5: r = 4'hA;
      3'd6: r = 4'h6;
      default: r = FOUR_PRI7;
    endcase
    return r;
  endfunction

endpackage

[rtl/w8b10b_front.sv]
// Front end: splits a data word into bytes and classifies each one.
module w8b10b_front (
  input  logic [w8b10b_pkg::DATA_W-1:0] data_i,
  output w8b10b_pkg::word_class_t       class_o
);
  import w8b10b_pkg::*;

  // Per-lane table lookup and balance check
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic [4:0] x;
      logic [2:0] y;
      logic [5:0] six;
      x   = data_i[8*k +: 5];
      y   = data_i[8*k+5 +: 3];
      six = six_neg_f(x);
      class_o[k].six   = six;
      class_o[k].unbal = ($countones(six) != 3);
      class_o[k].flip6 = ($countones(six) != 3) || (x == 5'd7);
      class_o[k].four  = four_neg_f(y);
      class_o[k].y     = y;
    end
  end

endmodule

[rtl/w8b10b_queue.sv]
// Two-entry queue between front end and back end.
module w8b10b_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  w8b10b_pkg::word_class_t push_data_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    valid_o,
  output w8b10b_pkg::word_class_t pop_data_o
);
  import w8b10b_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  word_class_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]          count_q, count_d;

  assign full_o     = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/w8b10b_back.sv]
// Back end: disparity chain over the four lanes and the output register.
module w8b10b_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  w8b10b_pkg::word_class_t             class_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [w8b10b_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import w8b10b_pkg::*;

  logic                rd_q, rd_d;
  logic                out_valid_q, out_valid_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic                end_rd_q;
  logic [LANES:0]      rd_chain;

  // Take a word when the output register is free or being emptied
  assign pop_o = valid_i && (!out_valid_q || m_axis_tready);

  // Four symbols, disparity carried lane to lane
  always_comb begin
    rd_chain[0] = rd_q;
    for (int k = 0; k < LANES; k++) begin
      logic [5:0] six;
      logic [3:0] four;
      logic       rd_mid;
      logic       alt;
      logic       flip4;
      six    = (rd_chain[k] && class_i[k].flip6) ? ~class_i[k].six : class_i[k].six;
      rd_mid = rd_chain[k] ^ class_i[k].unbal;
      alt    = (!rd_mid && (six[1:0] == 2'b11)) || (rd_mid && (six[1:0] == 2'b00));
      four   = class_i[k].four;
      if (class_i[k].y == Y_D7) begin
        four = alt ? FOUR_ALT7 : FOUR_PRI7;
      end
      flip4 = (class_i[k].y == Y_D0) || (class_i[k].y == Y_D3) ||
              (class_i[k].y == Y_D4) || (class_i[k].y == Y_D7);
      if (flip4 && rd_mid) begin
        four = ~four;
      end
      code_d[10*k +: 10] = {four, six};
      rd_chain[k+1] = rd_mid ^ ((class_i[k].y == Y_D0) || (class_i[k].y == Y_D4) ||
                                (class_i[k].y == Y_D7));
    end
  end

  // Control state
  always_comb begin
    rd_d        = pop_o ? rd_chain[LANES] : rd_q;
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      code_q   <= code_d;
      end_rd_q <= rd_chain[LANES];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-CODE_W-1)'(0), end_rd_q, code_q};

endmodule

[rtl/word_8b10b_encoder.sv]
// Top level of the word 8b/10b encoder.
//
// Input stream (s_axis): one 32-bit data word per transfer, byte 0 in
// bits 7..0. Each byte becomes one 10-bit data symbol, byte 0 first.
// Output stream (m_axis): bits 39..0 hold the four symbols (byte 0 symbol
// in bits 9..0, fghj in bits 9..6 and abcdei in bits 5..0 of each),
// bit 40 the running disparity after the fourth symbol (1 positive),
// bits 47..41 are zero.
// A word accepted on s_axis is written into the queue, then into the output
// register, and is presented on m_axis from there.
// Throughput: one word per cycle while m_axis_tready stays high; the
// four-lane disparity chain in the back end is combinational.
// A two-entry queue sits between the byte classifier and the encoder
// stage, so s_axis_tready drops only once both entries are held while the
// output register waits on m_axis_tready. Nothing is lost or repeated.
// Reset empties the queue and the output register and sets the running
// disparity to negative.
module word_8b10b_encoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [w8b10b_pkg::DATA_W-1:0]      s_axis_tdata,  // [31:0] data_word
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [39:0] code_word, [40] end_disparity, [47:41] zero
  output logic [w8b10b_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import w8b10b_pkg::*;

  word_class_t front_class;
  word_class_t head_class;
  logic        queue_full;
  logic        queue_valid;
  logic        queue_pop;
  logic        queue_push;

  assign s_axis_tready = !queue_full;
  assign queue_push    = s_axis_tvalid && !queue_full;

  // Classify bytes
  w8b10b_front u_front (
    .data_i  (s_axis_tdata),
    .class_o (front_class)
  );

  // Decoupling queue
  w8b10b_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (queue_push),
    .push_data_i (front_class),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (head_class)
  );

  // Encode with running disparity
  w8b10b_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (queue_valid),
    .class_i       (head_class),
    .pop_o         (queue_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[rtl/w8b10b_checker.sv]
// Port-level checks for the word 8b/10b encoder, bound to the top level.
module w8b10b_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [w8b10b_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import w8b10b_pkg::*;

  // A stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // Padding above the disparity bit stays clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:CODE_W+1] == '0))
    else $error("output padding not zero");

  // Every symbol carries four, five or six ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($countones(m_axis_tdata[9:0])   >= 4) && ($countones(m_axis_tdata[9:0])   <= 6) &&
      ($countones(m_axis_tdata[19:10]) >= 4) && ($countones(m_axis_tdata[19:10]) <= 6) &&
      ($countones(m_axis_tdata[29:20]) >= 4) && ($countones(m_axis_tdata[29:20]) <= 6) &&
      ($countones(m_axis_tdata[39:30]) >= 4) && ($countones(m_axis_tdata[39:30]) <= 6))
    else $error("symbol out of disparity bounds");

  // A last symbol with six ones leaves the reported ending disparity positive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ($countones(m_axis_tdata[39:30]) == 6) |-> m_axis_tdata[CODE_W])
    else $error("positive symbol left negative disparity");

  // Nothing offered as reset is released
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

bind word_8b10b_encoder w8b10b_checker u_w8b10b_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[dv/word_8b10b_encoder_tb.sv]
// Self-checking testbench for the word 8b/10b encoder: predicted symbols vs. output stream.
`timescale 1ns / 100ps

module word_8b10b_encoder_tb;
  import w8b10b_pkg::*;

  localparam int unsigned HOLD_CYCLES = 200;   // long output stall
  localparam int unsigned STALL_LIMIT = 5000;  // cycles without any word moving
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam logic [4:0]  X_D7        = 5'd7;  // the neutral 6b block with two forms

  // abcdei for negative running disparity, indexed by EDCBA
  localparam logic [5:0] SIX_CODE_NEG [32] = '{
    6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
    6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
    6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
    6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
  };

  // fghj for negative running disparity, indexed by HGF (primary D.x.7)
  localparam logic [3:0] FOUR_CODE_NEG [8] = '{
    4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, FOUR_PRI7
  };

  // Bytes that hit the two-form and alternate D.x.7 cases
  localparam logic [7:0] TRICKY_BYTES [12] = '{
    8'hF1, 8'hF2, 8'hF4, 8'hEB, 8'hED, 8'hEE,
    8'h07, 8'h67, 8'hE7, 8'h63, 8'h83, 8'h00
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              disp;
  } coded_word_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [DATA_W-1:0] words_to_send [$];
  coded_word_t       expected_codes [$];
  logic              model_rd = 1'b0;   // predicted running disparity
  int unsigned       send_idle_pct = 12;
  int unsigned       recv_idle_pct = 85;
  logic              hold_req  = 1'b0;  // toggled to request a long output stall
  logic              hold_seen = 1'b0;
  int unsigned       hold_left = 0;
  int unsigned       error_count = 0;
  int unsigned       words_in = 0;
  int unsigned       words_out = 0;
  int unsigned       quiet_cycles = 0;

  word_8b10b_encoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] data_word
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [39:0] code_word, [40] end_disparity, [47:41] zero
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Encode four bytes, byte 0 first, carrying the disparity through
  function automatic logic [CODE_W-1:0] encode_word(input logic [DATA_W-1:0] w,
                                                    inout logic rd);
    logic [CODE_W-1:0] code;
    logic [7:0]        b;
    logic [5:0]        six;
    logic [3:0]        four;
    logic              unbal;
    logic              alt;
    code = '0;
    for (int k = 0; k < LANES; k++) begin
      b     = w[8*k +: 8];
      six   = SIX_CODE_NEG[b[4:0]];
      unbal = ($countones(six) != 3);
      if (rd && (unbal || b[4:0] == X_D7)) six = ~six;
      if (unbal) rd = ~rd;
      if (b[7:5] == Y_D7) begin
        // alternate form avoids a run of five after e,i
        alt  = (!rd && six[1:0] == 2'b11) || (rd && six[1:0] == 2'b00);
        four = alt ? FOUR_ALT7 : FOUR_PRI7;
      end else begin
        four = FOUR_CODE_NEG[b[7:5]];
      end
      if (rd && (b[7:5] == Y_D0 || b[7:5] == Y_D3 || b[7:5] == Y_D4 || b[7:5] == Y_D7))
        four = ~four;
      if (b[7:5] == Y_D0 || b[7:5] == Y_D4 || b[7:5] == Y_D7) rd = ~rd;
      code[10*k +: 10] = {four, six};
    end
    return code;
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) < 3) return TRICKY_BYTES[$urandom_range(11)];
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_random_words(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      words_to_send.push_back({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
  endtask

  // Let every queued word go in and every result come out
  task automatic wait_drained();
    while (words_to_send.size() != 0 || s_axis_tvalid || expected_codes.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: predicts on acceptance, then offers the next word or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin : drive
      coded_word_t exp_w;
      if (s_axis_tvalid && s_axis_tready) begin
        exp_w.code = encode_word(s_axis_tdata, model_rd);
        exp_w.disp = model_rd;
        expected_codes.push_back(exp_w);
        words_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= words_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output word, then paces m_axis_tready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= 1'b0;
      hold_left     <= 0;
    end else begin : watch
      coded_word_t exp_w;
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (expected_codes.size() == 0) begin
          $error("unexpected output word %h", m_axis_tdata);
          error_count++;
        end else begin
          exp_w = expected_codes.pop_front();
          if (m_axis_tdata[CODE_W-1:0] !== exp_w.code) begin
            $error("code_word: expected %h, got %h", exp_w.code, m_axis_tdata[CODE_W-1:0]);
            error_count++;
          end
          if (m_axis_tdata[CODE_W] !== exp_w.disp) begin
            $error("end_disparity: expected %b, got %b", exp_w.disp, m_axis_tdata[CODE_W]);
            error_count++;
          end
          if (m_axis_tdata[OUT_TDATA_W-1:CODE_W+1] !== '0) begin
            $error("pad bits: expected 0, got %h", m_axis_tdata[OUT_TDATA_W-1:CODE_W+1]);
            error_count++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen     <= hold_req;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, two-form blocks, alternate D.x.7 in both disparities
    words_to_send.push_back(32'h0000_0000);
    words_to_send.push_back(32'hFFFF_FFFF);
    words_to_send.push_back(32'hF1F2_F4F1);
    words_to_send.push_back(32'hEBED_EEEB);
    words_to_send.push_back(32'h00EB_00ED);
    words_to_send.push_back(32'h1CEE_1CEB);
    words_to_send.push_back(32'h6707_6707);
    words_to_send.push_back(32'hE7E7_E7E7);
    words_to_send.push_back(32'h6363_6363);
    words_to_send.push_back(32'h8383_8383);
    words_to_send.push_back(32'hF100_F200);
    words_to_send.push_back(32'h0707_0707);
    words_to_send.push_back(32'hAAAA_AAAA);
    words_to_send.push_back(32'h5555_5555);
    words_to_send.push_back(32'h1F1F_1F1F);
    words_to_send.push_back(32'hE0E0_E0E0);
    words_to_send.push_back(32'h807F_807F);
    words_to_send.push_back(32'hFE01_FE01);
    words_to_send.push_back(32'hEBF4_EDF1);
    words_to_send.push_back(32'hEEF2_17E7);

    // Slow receiver, with one long stall to back up the input
    hold_req <= ~hold_req;
    queue_random_words(490);
    wait_drained();

    // Slow sender, fast receiver
    send_idle_pct = 85;
    recv_idle_pct = 12;
    queue_random_words(520);
    wait_drained();

    // Full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_words(520);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Encoded %0d words (%0d checked) over slow-sink, slow-source and full-rate pacing,",
             words_in, words_out);
    $display("with a %0d-cycle output stall and disparity carried across every word.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
